/* rtl/core/prtb_pkg.sv */
package prtb_pkg;

  localparam int TIMER_COUNT_DEF = 4;
  localparam int CYCLE_WIDTH_DEF = 10;

  // item function codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // register page
  localparam logic [9:0] TMR_BASE   = 10'h100;
  localparam logic [9:0] FLAG_REG   = 10'h202;
  localparam int         FLAG_SHIFT = 3;
  localparam int         REM_WIDTH  = 10;

  // control word bits
  localparam int CTRL_CASCADE = 2;
  localparam int CTRL_IRQ     = 6;
  localparam int CTRL_START   = 7;

  // controller commands
  typedef struct packed {
    logic capture;
    logic access;
    logic adv;
    logic div_step;
    logic fin;
    logic next_timer;
    logic load_out;
  } prtb_cmd_t;

  // datapath status
  typedef struct packed {
    logic is_tick;
    logic active;
    logic wrap;
    logic div_done;
    logic last_timer;
    logic out_busy;
  } prtb_status_t;

  // prescaler select to shift amount
  function automatic logic [3:0] div_shift(input logic [1:0] sel);
    case (sel)
      2'd0:    div_shift = 4'd0;
      2'd1:    div_shift = 4'd6;
      2'd2:    div_shift = 4'd8;
      default: div_shift = 4'd10;
    endcase
  endfunction

  // prescaler remainder mask
  function automatic logic [REM_WIDTH-1:0] rem_mask(input logic [1:0] sel);
    case (sel)
      2'd0:    rem_mask = 10'h000;
      2'd1:    rem_mask = 10'h03F;
      2'd2:    rem_mask = 10'h0FF;
      default: rem_mask = 10'h3FF;
    endcase
  endfunction

endpackage

/* rtl/core/prtb_ctrl.sv */
module prtb_ctrl
  import prtb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  prtb_status_t status,
  output prtb_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_ADV  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_NEXT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (status.is_tick) begin
          state_next = S_ADV;
        end else begin
          cmd.access = 1'b1;
          state_next = S_DONE;
        end
      end
      S_ADV: begin
        cmd.adv = 1'b1;
        state_next = (status.active && status.wrap) ? S_DIV : S_NEXT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (status.last_timer) begin
          state_next = S_DONE;
        end else begin
          cmd.next_timer = 1'b1;
          state_next = S_ADV;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // a transfer in starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DISP))
    else $error("accepted item did not start dispatch");
  // divider only runs for a wrap
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ($past(state) == S_ADV || $past(state) == S_DIV))
    else $error("divider entered out of order");
  // result load only after done
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (state == S_IDLE))
    else $error("result load left controller busy");

endmodule

/* rtl/core/prtb_datapath.sv */
module prtb_datapath
  import prtb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int CYCLE_WIDTH = CYCLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             func,
  input  logic [CYCLE_WIDTH-1:0] tick_cycles,
  input  logic [9:0]             reg_offset,
  input  logic [15:0]            write_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            read_data,
  output logic                   address_hit,
  output logic [3:0]             interrupt_flags,
  input  prtb_cmd_t              cmd,
  output prtb_status_t           status
);

  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int TW = ((CYCLE_WIDTH > REM_WIDTH) ? CYCLE_WIDTH : REM_WIDTH) + 1;
  localparam int DW = (TW > 17) ? TW : 17;
  localparam int CW = $clog2(DW + 1);

  // timer state
  logic [15:0]          count_value    [TIMER_COUNT];
  logic [15:0]          reload_value   [TIMER_COUNT];
  logic [15:0]          control_word   [TIMER_COUNT];
  logic [15:0]          readback_value [TIMER_COUNT];
  logic [REM_WIDTH-1:0] prescale_rem   [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] flags;

  // captured item
  logic [1:0]             func_q;
  logic [CYCLE_WIDTH-1:0] cycles_q;
  logic [15:0]            data_q;
  logic                   flag_sel, tmr_sel, high_sel;
  logic [IW-1:0]          sel;

  // divider
  logic [DW-1:0] div_num;
  logic [16:0]   div_per;
  logic [16:0]   div_rem;
  logic [CW-1:0] div_cnt;

  // result
  logic [15:0] rdata_q;
  logic        hit_q;

  // offset decode
  logic [9:0] rel;
  logic       dec_tmr;
  assign rel     = reg_offset - TMR_BASE;
  assign dec_tmr = !reg_offset[0] && (reg_offset >= TMR_BASE) &&
                   ({22'd0, rel} < 32'(4 * TIMER_COUNT));

  // tick evaluation for the selected timer
  logic [15:0]   ctrl;
  logic [TW-1:0] total, ticks;
  logic [DW-1:0] ticks_x, gap_x, over;
  logic [16:0]   gap, period;
  logic          active, wrap;
  assign ctrl    = control_word[sel];
  assign active  = ctrl[CTRL_START] && !ctrl[CTRL_CASCADE];
  assign total   = TW'(prescale_rem[sel]) + TW'(cycles_q);
  assign ticks   = total >> div_shift(ctrl[1:0]);
  assign gap     = 17'h10000 - {1'b0, count_value[sel]};
  assign period  = 17'h10000 - {1'b0, reload_value[sel]};
  assign ticks_x = DW'(ticks);
  assign gap_x   = DW'(gap);
  assign wrap    = ticks_x >= gap_x;
  assign over    = ticks_x - gap_x;

  // one restoring step
  logic [17:0] r_sh, r_sub;
  assign r_sh  = {div_rem, div_num[DW-1]};
  assign r_sub = r_sh - {1'b0, div_per};

  assign status.is_tick    = (func_q == FUNC_TICK);
  assign status.active     = active;
  assign status.wrap       = wrap;
  assign status.div_done   = (div_cnt == CW'(1));
  assign status.last_timer = (sel == IW'(TIMER_COUNT - 1));
  assign status.out_busy   = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        count_value[i]    <= '0;
        reload_value[i]   <= '0;
        control_word[i]   <= '0;
        readback_value[i] <= '0;
        prescale_rem[i]   <= '0;
      end
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register
      if (cmd.load_out) begin
        out_valid       <= 1'b1;
        read_data       <= rdata_q;
        address_hit     <= hit_q;
        interrupt_flags <= 4'(flags);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cmd.capture) begin
        func_q   <= func;
        cycles_q <= tick_cycles;
        data_q   <= write_data;
        flag_sel <= (reg_offset == FLAG_REG);
        tmr_sel  <= dec_tmr;
        high_sel <= rel[1];
        sel      <= (func == FUNC_TICK || !dec_tmr) ? '0 : IW'(rel[9:2]);
        rdata_q  <= '0;
        hit_q    <= 1'b0;
      end

      // register access
      if (cmd.access) begin
        if (func_q == FUNC_WRITE) begin
          if (flag_sel) begin
            hit_q <= 1'b1;
            flags <= flags & ~data_q[FLAG_SHIFT +: TIMER_COUNT];
          end else if (tmr_sel) begin
            hit_q <= 1'b1;
            if (!high_sel) begin
              reload_value[sel]   <= data_q;
              readback_value[sel] <= data_q;
            end else begin
              if (!control_word[sel][CTRL_START] && data_q[CTRL_START])
                count_value[sel] <= reload_value[sel];
              control_word[sel] <= data_q;
            end
          end
        end else if (func_q == FUNC_READ) begin
          if (flag_sel) begin
            hit_q   <= 1'b1;
            rdata_q <= 16'({flags, FLAG_SHIFT'(0)});
          end else if (tmr_sel) begin
            hit_q   <= 1'b1;
            rdata_q <= high_sel ? control_word[sel] : readback_value[sel];
          end
        end
      end

      // advance selected timer
      if (cmd.adv && active) begin
        prescale_rem[sel] <= total[REM_WIDTH-1:0] & rem_mask(ctrl[1:0]);
        if (!wrap) begin
          count_value[sel]    <= count_value[sel] + ticks[15:0];
          readback_value[sel] <= count_value[sel] + ticks[15:0];
        end else begin
          div_num <= over;
          div_per <= period;
          div_rem <= '0;
          div_cnt <= CW'(DW);
        end
      end

      if (cmd.div_step) begin
        div_num <= {div_num[DW-2:0], 1'b0};
        div_rem <= r_sub[17] ? r_sh[16:0] : r_sub[16:0];
        div_cnt <= div_cnt - CW'(1);
      end

      // wrap: reload plus leftover
      if (cmd.fin) begin
        count_value[sel]    <= reload_value[sel] + div_rem[15:0];
        readback_value[sel] <= reload_value[sel] + div_rem[15:0];
        if (control_word[sel][CTRL_IRQ]) flags[sel] <= 1'b1;
      end

      if (cmd.next_timer) sel <= sel + IW'(1);
    end
  end

  // divider remainder stays below divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> ({1'b0, div_rem} < {1'b0, div_per}))
    else $error("divider remainder out of range");
  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_data)))
    else $error("stalled result changed");
  // divider never starts with a zero divisor
  a_per_nz: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (div_per != 17'd0))
    else $error("zero divisor");

endmodule

/* rtl/core/prescaled_reload_timer_bank_core.sv */
// Write, read or unused item: captured in S_IDLE, accessed in S_DISP, result loaded in S_DONE.
// Tick item: each timer is advanced in turn, plus a DW-bit division (DW = max(CYCLE_WIDTH+1, 17))
//   for each timer that wraps, by the bit-serial modulo unit shared by all timers.
// Throughput: one item at a time; the next transfer is taken in the cycle after the result loads.
//   A waiting result holds only the result load, not the next transfer.
// Reset (rst, synchronous): all timers stopped, counters, reloads and flags zero.
module prescaled_reload_timer_bank_core
  import prtb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int CYCLE_WIDTH = CYCLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             func,
  input  logic [CYCLE_WIDTH-1:0] tick_cycles,
  input  logic [9:0]             reg_offset,
  input  logic [15:0]            write_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            read_data,
  output logic                   address_hit,
  output logic [3:0]             interrupt_flags
);

  prtb_cmd_t    cmd;
  prtb_status_t status;

  prtb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  prtb_datapath #(
    .TIMER_COUNT (TIMER_COUNT),
    .CYCLE_WIDTH (CYCLE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .func            (func),
    .tick_cycles     (tick_cycles),
    .reg_offset      (reg_offset),
    .write_data      (write_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_data       (read_data),
    .address_hit     (address_hit),
    .interrupt_flags (interrupt_flags),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

/* tb/testbench.sv */
module testbench;
  import prtb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTMR = 4;
  localparam int LIMIT = 3000000;

  // expected result of one transfer
  typedef struct packed {
    logic [15:0] rdata;
    logic        hit;
    logic [3:0]  flags;
  } timer_resp_t;

  // scoreboard with its own copy of the timer bank
  class timer_bank_sb;
    logic [15:0] cnt[NTMR];
    logic [15:0] rld[NTMR];
    logic [15:0] ctl[NTMR];
    logic [15:0] rbk[NTMR];
    logic [9:0]  rem[NTMR];
    logic [3:0]  flg;
    timer_resp_t pending[$];
    int errors;

    function void clear();
      for (int i = 0; i < NTMR; i++) begin
        cnt[i] = 0; rld[i] = 0; ctl[i] = 0; rbk[i] = 0; rem[i] = 0;
      end
      flg = 0;
      errors = 0;
    endfunction

    function void advance(int i, int unsigned cyc);
      int unsigned sh, total, ticks, gap, period, c;
      if (!ctl[i][CTRL_START] || ctl[i][CTRL_CASCADE]) return;
      case (ctl[i][1:0])
        2'd0: sh = 0;
        2'd1: sh = 6;
        2'd2: sh = 8;
        default: sh = 10;
      endcase
      total = rem[i] + cyc;
      ticks = total >> sh;
      rem[i] = 10'(total & ((1 << sh) - 1));
      c = cnt[i];
      gap = 32'h10000 - c;
      if (ticks < gap) c = c + ticks;
      else begin
        ticks = ticks - gap;
        period = 32'h10000 - rld[i];
        c = rld[i] + (ticks % period);
        if (ctl[i][CTRL_IRQ]) flg[i] = 1'b1;
      end
      cnt[i] = 16'(c);
      rbk[i] = 16'(c);
    endfunction

    // note an accepted input and queue its expected result
    function void note_transfer(logic [1:0] f, logic [9:0] cyc, logic [9:0] off,
                                logic [15:0] d);
      timer_resp_t r;
      int idx;
      r = '0;
      idx = (off - TMR_BASE) >> 2;
      if (f == FUNC_TICK) begin
        for (int i = 0; i < NTMR; i++) advance(i, cyc);
      end else if (f == FUNC_WRITE) begin
        if (off == FLAG_REG) begin
          r.hit = 1;
          flg = flg & ~4'(d >> FLAG_SHIFT);
        end else if (!off[0] && off >= TMR_BASE && off < TMR_BASE + 4 * NTMR) begin
          r.hit = 1;
          if (!off[1]) begin
            rld[idx] = d; rbk[idx] = d;
          end else begin
            if (!ctl[idx][CTRL_START] && d[CTRL_START]) cnt[idx] = rld[idx];
            ctl[idx] = d;
          end
        end
      end else if (f == FUNC_READ) begin
        if (off == FLAG_REG) begin
          r.hit = 1;
          r.rdata = 16'(flg) << FLAG_SHIFT;
        end else if (!off[0] && off >= TMR_BASE && off < TMR_BASE + 4 * NTMR) begin
          r.hit = 1;
          r.rdata = off[1] ? ctl[idx] : rbk[idx];
        end
      end
      r.flags = flg;
      pending.push_back(r);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(timer_resp_t got);
      timer_resp_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp rdata %h hit %b flags %h, got rdata %h hit %b flags %h",
                   exp.rdata, exp.hit, exp.flags, got.rdata, got.hit, got.flags);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [1:0] func = 0;
  logic [9:0] tick_cycles = 0, reg_offset = 0;
  logic [15:0] write_data = 0;
  logic out_valid, out_stall = 0;
  logic [15:0] read_data;
  logic address_hit;
  logic [3:0] interrupt_flags;

  int src_idle = 0, dst_stall = 0;
  int unsigned cycles = 0;
  timer_bank_sb sb = new();

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  prescaled_reload_timer_bank_core u_top (.*);

  // receiver: random stall, check on each transfer
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result({read_data, address_hit, interrupt_flags});
      out_stall <= ($urandom_range(99) < dst_stall);
    end
  end

  // run timeout
  always @(posedge clk) if (cycles > LIMIT) begin
    $display("Verification failed");
    $finish;
  end

  // one transfer, with random idle cycles in front; valid stays up for a following transfer
  task automatic send(logic [1:0] f, logic [9:0] cyc, logic [9:0] off, logic [15:0] d);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; func <= f; tick_cycles <= cyc; reg_offset <= off; write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(f, cyc, off, d);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_offset();
    int k;
    k = $urandom_range(99);
    if (k < 75) return TMR_BASE + 10'($urandom_range(4 * NTMR - 1) & ~1);
    if (k < 85) return FLAG_REG;
    if (k < 90) return TMR_BASE + 10'($urandom_range(4 * NTMR - 1) | 1);
    return 10'($urandom);
  endfunction

  // random item, mostly well-formed timer setup and ticks
  task automatic random_item();
    int k;
    logic [15:0] d;
    k = $urandom_range(99);
    d = 16'($urandom);
    if (k < 40) send(FUNC_TICK, 10'($urandom), 10'($urandom), 16'($urandom));
    else if (k < 55) begin
      // reload high so wraps happen often
      if ($urandom_range(1)) d[15:8] = 8'hFF;
      send(FUNC_WRITE, 10'($urandom), TMR_BASE + 10'(4 * $urandom_range(NTMR - 1)), d);
    end else if (k < 68) begin
      if ($urandom_range(3) != 0) d[CTRL_CASCADE] = 0;
      send(FUNC_WRITE, 10'($urandom), TMR_BASE + 10'(4 * $urandom_range(NTMR - 1) + 2), d);
    end else if (k < 92) send(FUNC_READ, 10'($urandom), pick_offset(), d);
    else if (k < 97) send(FUNC_WRITE, 10'($urandom), pick_offset(), d);
    else send(FUNC_UNUSED, 10'($urandom), pick_offset(), d);
  endtask

  initial begin
    sb.clear();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: start timers at each divider, ticks at extremes, flags, misses
    send(FUNC_READ, 0, TMR_BASE, 0);
    for (int i = 0; i < NTMR; i++) begin
      send(FUNC_WRITE, 0, TMR_BASE + 10'(4 * i), 16'hFFF0 + 16'(i));
      send(FUNC_WRITE, 0, TMR_BASE + 10'(4 * i + 2), 16'h00C0 | 16'(i));
    end
    send(FUNC_TICK, 10'h3FF, 0, 0);
    send(FUNC_TICK, 10'h3FF, 10'h3FF, 16'hFFFF);
    send(FUNC_TICK, 0, 0, 0);
    send(FUNC_READ, 0, FLAG_REG, 0);
    send(FUNC_READ, 0, TMR_BASE + 2, 0);
    send(FUNC_READ, 0, TMR_BASE + 12, 0);
    send(FUNC_WRITE, 0, FLAG_REG, 16'hFFFF);
    send(FUNC_WRITE, 0, TMR_BASE + 1, 16'hFFFF);
    send(FUNC_READ, 0, TMR_BASE + 1, 0);
    send(FUNC_READ, 0, 10'h3FE, 0);
    send(FUNC_UNUSED, 10'h3FF, FLAG_REG, 16'hFFFF);
    send(FUNC_WRITE, 0, TMR_BASE + 6, 16'h0084);
    send(FUNC_WRITE, 0, TMR_BASE, 16'h0000);
    send(FUNC_WRITE, 0, TMR_BASE + 2, 16'h00C0);
    send(FUNC_TICK, 10'h3FF, 0, 0);
    send(FUNC_READ, 0, TMR_BASE, 0);
    drain();

    // random phases with different idle and stall rates
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin src_idle = 0;  dst_stall = 0;  end
        1: begin src_idle = 87; dst_stall = 0;  end
        2: begin src_idle = 0;  dst_stall = 87; end
        3: begin src_idle = 21; dst_stall = 21; end
        default: begin src_idle = 0; dst_stall = 0; end
      endcase
      for (int n = 0; n < 340; n++) begin
        random_item();
        if (n == 170) drain();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
